// ===== hw/rtl/cluster_first_fit_core_placer_defines.svh =====
// ----------------------------------------------------------------------------
// cluster_first_fit_core_placer_defines
// assertion macros used by the placer back end rtl
// ----------------------------------------------------------------------------
`ifndef CLUSTER_FIRST_FIT_CORE_PLACER_DEFINES_SVH
`define CLUSTER_FIRST_FIT_CORE_PLACER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, idle while reset is low
`define CFFCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also during reset
`define CFFCP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFFCP_ASSERT(lbl, prop, msg)
`define CFFCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/cffcp_pkg.sv =====
// ----------------------------------------------------------------------------
// cffcp_pkg
// types, constants and helpers of the cluster first-fit core placer
// ----------------------------------------------------------------------------
package cffcp_pkg;

    localparam int MAX_CORES_DEF = 256;
    localparam int QDEPTH        = 2;
    localparam int DIV_W         = 17;
    localparam int CFG_W         = 9;
    localparam logic [15:0] LOAD_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        DEC_NONE,
        DEC_CLUSTER,
        DEC_NODE,
        DEC_PACKAGE,
        DEC_UNBIND,
        DEC_RECORDED,
        DEC_RANGE
    } decision_t;

    typedef enum logic [2:0] {
        BW_LOW,
        BW_DIE,
        BW_PACKAGE,
        BW_ALL,
        BW_UNSPEC
    } bw_class_t;

    typedef enum logic [1:0] {
        CFG_CPC,
        CFG_CPN,
        CFG_CPP
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_DONE,
        KIND_OCCUPY,
        KIND_LOW,
        KIND_NODE
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_OCC_DIV2,
        ST_OCC_RD,
        ST_OCC_WR,
        ST_LOW_MUL,
        ST_LOW_START,
        ST_LOW_CHK,
        ST_LOW_CMP,
        ST_LOW_NRD,
        ST_LOW_WR,
        ST_NODE_CHK,
        ST_NODE_CMP
    } back_state_t;

    // effective register values, zero already mapped to one
    typedef struct packed {
        logic [CFG_W-1:0] cpc;
        logic [CFG_W-1:0] cpn;
        logic [CFG_W-1:0] cpp;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        decision_t   decision;
        logic [8:0]  target;
        logic [7:0]  home;
        logic [8:0]  demand;
        logic [21:0] tag;
        logic [7:0]  core;
    } cmd_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [CFG_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    function automatic logic [15:0] sat_add(input logic [15:0] cur, input logic [8:0] add);
        logic [16:0] s;
        s = {1'b0, cur} + {8'd0, add};
        return s[16] ? LOAD_MAX : s[15:0];
    endfunction

    function automatic logic [CFG_W-1:0] reg_or_one(input logic [CFG_W-1:0] v);
        return (v == '0) ? CFG_W'(1) : v;
    endfunction

endpackage

// ===== hw/rtl/cffcp_front.sv =====
// ----------------------------------------------------------------------------
// cffcp_front
// accepts request beats and sorts them into commands for the back end
// ----------------------------------------------------------------------------
module cffcp_front #(
    parameter int MAX_CORES = cffcp_pkg::MAX_CORES_DEF
) (
    input  logic                 start,
    output logic                 busy,
    input  logic                 operation,
    input  logic signed [8:0]    home_node,
    input  logic [2:0]           bandwidth_class,
    input  logic [8:0]           demand,
    input  logic [21:0]          task_tag,
    input  logic [7:0]           core_index,
    input  cffcp_pkg::q_status_t q_status,
    input  logic                 clearing,
    output logic                 push,
    output cffcp_pkg::cmd_t      cmd
);

    assign busy = q_status.full || clearing;
    assign push = start && !busy;

    always_comb
    begin
        cmd          = '0;
        cmd.home     = home_node[7:0];
        cmd.demand   = demand;
        cmd.tag      = task_tag;
        cmd.core     = core_index;
        cmd.kind     = cffcp_pkg::KIND_DONE;
        cmd.decision = cffcp_pkg::DEC_NONE;
        cmd.target   = '0;
        if (operation)
        begin
            if (32'(core_index) >= MAX_CORES)
            begin
                cmd.decision = cffcp_pkg::DEC_RANGE;
            end
            else
            begin
                cmd.kind = cffcp_pkg::KIND_OCCUPY;
            end
        end
        else if (!home_node[8])
        begin
            // non-negative home node: sort by bandwidth class
            case (bandwidth_class)
                cffcp_pkg::BW_LOW:
                begin
                    cmd.kind = cffcp_pkg::KIND_LOW;
                end
                cffcp_pkg::BW_DIE:
                begin
                    cmd.kind = cffcp_pkg::KIND_NODE;
                end
                cffcp_pkg::BW_ALL:
                begin
                    cmd.decision = cffcp_pkg::DEC_UNBIND;
                end
                default:
                begin
                    // package, unspecified and unknown classes
                    cmd.decision = cffcp_pkg::DEC_PACKAGE;
                    cmd.target   = {1'b0, home_node[7:0]};
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/cffcp_queue.sv =====
// ----------------------------------------------------------------------------
// cffcp_queue
// short command queue between front and back end
// ----------------------------------------------------------------------------
module cffcp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cffcp_pkg::cmd_t      push_cmd,
    input  logic                 pop,
    output cffcp_pkg::q_status_t status,
    output cffcp_pkg::cmd_t      head
);

    localparam int QAW = (cffcp_pkg::QDEPTH > 1) ? $clog2(cffcp_pkg::QDEPTH) : 1;
    localparam int CW  = $clog2(cffcp_pkg::QDEPTH + 1);

    cffcp_pkg::cmd_t entry_reg [cffcp_pkg::QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        return (32'(p) == cffcp_pkg::QDEPTH - 1) ? '0 : QAW'(p + 1'b1);
    endfunction

    assign status.valid = (count_reg != '0);
    assign status.full  = (32'(count_reg) == cffcp_pkg::QDEPTH);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/cffcp_div.sv =====
// ----------------------------------------------------------------------------
// cffcp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cffcp_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cffcp_pkg::div_req_t   req,
    output cffcp_pkg::div_rsp_t   rsp
);

    localparam int DW = cffcp_pkg::DIV_W;
    localparam int RW = cffcp_pkg::CFG_W;
    localparam int NW = $clog2(DW);

    logic [DW-1:0] quo_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] den_reg;
    logic [NW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [RW:0]   rem_sh;
    logic          ge;
    logic [RW-1:0] rem_next;
    logic [DW-1:0] quo_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DW-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? RW'(rem_sh - {1'b0, den_reg}) : RW'(rem_sh);
        quo_next = {quo_reg[DW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= NW'(DW - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= NW'(cnt_reg - 1'b1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/cffcp_back.sv =====
// ----------------------------------------------------------------------------
// cffcp_back
// executes queued commands against the cluster and node load counters
// ----------------------------------------------------------------------------
`include "cluster_first_fit_core_placer_defines.svh"

module cffcp_back #(
    parameter int MAX_CORES = cffcp_pkg::MAX_CORES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cffcp_pkg::cfg_t       cfg,
    input  cffcp_pkg::q_status_t  q_status,
    input  cffcp_pkg::cmd_t       q_head,
    output logic                  q_pop,
    output logic                  clearing,
    output cffcp_pkg::div_req_t   div_req,
    input  cffcp_pkg::div_rsp_t   div_rsp,
    output logic                  result_valid,
    output logic [2:0]            decision,
    output logic [8:0]            target,
    output logic [21:0]           task_tag_out
);

    localparam int AW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int DW = cffcp_pkg::DIV_W;

    cffcp_pkg::back_state_t state_reg, state_next;
    cffcp_pkg::back_state_t ret_reg, ret_next;
    cffcp_pkg::cmd_t        cmd_reg;

    logic [AW-1:0] clr_reg;
    logic [DW-1:0] core_reg;
    logic [DW-1:0] ccl_reg;
    logic [9:0]    i_reg;
    logic [AW-1:0] nidx_reg;

    logic [15:0]   cl_mem [MAX_CORES];
    logic [15:0]   nd_mem [MAX_CORES];
    logic [15:0]   cl_rd_reg;
    logic [15:0]   nd_rd_reg;

    logic                 res_valid_reg;
    cffcp_pkg::decision_t dec_reg;
    logic [8:0]           tgt_reg;
    logic [21:0]          tag_reg;

    logic                 emit;
    cffcp_pkg::decision_t emit_dec;
    logic [8:0]           emit_tgt;
    logic                 cl_re, nd_re, cl_we, nd_we;
    logic [AW-1:0]        nd_raddr, cl_waddr, nd_waddr;
    logic [15:0]          cl_wdata, nd_wdata;

    logic core_oor, home_oor, scan_done, cl_fit, nd_fit;

    always_comb
    begin
        core_oor  = 32'(core_reg) >= MAX_CORES;
        home_oor  = 32'(cmd_reg.home) >= MAX_CORES;
        scan_done = i_reg >= {1'b0, cfg.cpp};
        cl_fit    = ({1'b0, cl_rd_reg} + 17'(cmd_reg.demand)) <= 17'(cfg.cpc);
        nd_fit    = ({1'b0, nd_rd_reg} + 17'(cmd_reg.demand)) <= 17'(cfg.cpn);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            cffcp_pkg::ST_CLEAR:
            begin
                if (32'(clr_reg) == MAX_CORES - 1)
                begin
                    state_next = cffcp_pkg::ST_IDLE;
                end
            end
            cffcp_pkg::ST_IDLE:
            begin
                if (q_status.valid)
                begin
                    state_next = cffcp_pkg::ST_DISPATCH;
                end
            end
            cffcp_pkg::ST_DISPATCH:
            begin
                unique case (cmd_reg.kind)
                    cffcp_pkg::KIND_OCCUPY:
                    begin
                        state_next = cffcp_pkg::ST_DIV;
                        ret_next   = cffcp_pkg::ST_OCC_DIV2;
                    end
                    cffcp_pkg::KIND_LOW:  state_next = cffcp_pkg::ST_LOW_MUL;
                    cffcp_pkg::KIND_NODE: state_next = cffcp_pkg::ST_NODE_CHK;
                    default:              state_next = cffcp_pkg::ST_IDLE;
                endcase
            end
            cffcp_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ret_reg;
                end
            end
            cffcp_pkg::ST_OCC_DIV2:
            begin
                state_next = cffcp_pkg::ST_DIV;
                ret_next   = cffcp_pkg::ST_OCC_RD;
            end
            cffcp_pkg::ST_OCC_RD:    state_next = cffcp_pkg::ST_OCC_WR;
            cffcp_pkg::ST_OCC_WR:    state_next = cffcp_pkg::ST_IDLE;
            cffcp_pkg::ST_LOW_MUL:   state_next = cffcp_pkg::ST_LOW_START;
            cffcp_pkg::ST_LOW_START:
            begin
                state_next = cffcp_pkg::ST_DIV;
                ret_next   = cffcp_pkg::ST_LOW_CHK;
            end
            cffcp_pkg::ST_LOW_CHK:
            begin
                if (scan_done)
                begin
                    state_next = cffcp_pkg::ST_NODE_CHK;
                end
                else if (core_oor)
                begin
                    state_next = cffcp_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = cffcp_pkg::ST_LOW_CMP;
                end
            end
            cffcp_pkg::ST_LOW_CMP:
            begin
                if (cl_fit)
                begin
                    state_next = cffcp_pkg::ST_DIV;
                    ret_next   = cffcp_pkg::ST_LOW_NRD;
                end
                else
                begin
                    state_next = cffcp_pkg::ST_LOW_CHK;
                end
            end
            cffcp_pkg::ST_LOW_NRD:   state_next = cffcp_pkg::ST_LOW_WR;
            cffcp_pkg::ST_LOW_WR:    state_next = cffcp_pkg::ST_IDLE;
            cffcp_pkg::ST_NODE_CHK:
            begin
                state_next = home_oor ? cffcp_pkg::ST_IDLE : cffcp_pkg::ST_NODE_CMP;
            end
            cffcp_pkg::ST_NODE_CMP:  state_next = cffcp_pkg::ST_IDLE;
            default:                 state_next = cffcp_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        emit     = 1'b0;
        emit_dec = cffcp_pkg::DEC_NONE;
        emit_tgt = '0;
        cl_re    = 1'b0;
        nd_re    = 1'b0;
        cl_we    = 1'b0;
        nd_we    = 1'b0;
        cl_wdata = cffcp_pkg::sat_add(cl_rd_reg, cmd_reg.demand);
        nd_wdata = cffcp_pkg::sat_add(nd_rd_reg, cmd_reg.demand);
        nd_raddr = div_rsp.quotient[AW-1:0];
        q_pop    = 1'b0;
        unique case (state_reg)
            cffcp_pkg::ST_CLEAR:
            begin
                cl_we    = 1'b1;
                nd_we    = 1'b1;
                cl_wdata = '0;
                nd_wdata = '0;
            end
            cffcp_pkg::ST_IDLE:
            begin
                q_pop = q_status.valid;
            end
            cffcp_pkg::ST_DISPATCH:
            begin
                if (cmd_reg.kind == cffcp_pkg::KIND_DONE)
                begin
                    emit     = 1'b1;
                    emit_dec = cmd_reg.decision;
                    emit_tgt = cmd_reg.target;
                end
            end
            cffcp_pkg::ST_OCC_RD:
            begin
                cl_re = 1'b1;
                nd_re = 1'b1;
            end
            cffcp_pkg::ST_OCC_WR:
            begin
                cl_we    = 1'b1;
                nd_we    = 1'b1;
                cl_wdata = cffcp_pkg::sat_add(cl_rd_reg, 9'd1);
                nd_wdata = cffcp_pkg::sat_add(nd_rd_reg, 9'd1);
                emit     = 1'b1;
                emit_dec = cffcp_pkg::DEC_RECORDED;
                emit_tgt = {1'b0, cmd_reg.core};
            end
            cffcp_pkg::ST_LOW_CHK:
            begin
                if (!scan_done && core_oor)
                begin
                    emit     = 1'b1;
                    emit_dec = cffcp_pkg::DEC_RANGE;
                end
                else if (!scan_done)
                begin
                    cl_re = 1'b1;
                end
            end
            cffcp_pkg::ST_LOW_NRD:
            begin
                nd_re = 1'b1;
            end
            cffcp_pkg::ST_LOW_WR:
            begin
                cl_we    = 1'b1;
                nd_we    = 1'b1;
                emit     = 1'b1;
                emit_dec = cffcp_pkg::DEC_CLUSTER;
                emit_tgt = core_reg[8:0];
            end
            cffcp_pkg::ST_NODE_CHK:
            begin
                nd_raddr = AW'(cmd_reg.home);
                if (home_oor)
                begin
                    emit     = 1'b1;
                    emit_dec = cffcp_pkg::DEC_RANGE;
                end
                else
                begin
                    nd_re = 1'b1;
                end
            end
            cffcp_pkg::ST_NODE_CMP:
            begin
                nd_we    = nd_fit;
                emit     = 1'b1;
                emit_dec = nd_fit ? cffcp_pkg::DEC_NODE : cffcp_pkg::DEC_PACKAGE;
                emit_tgt = {1'b0, cmd_reg.home};
            end
            default:
            begin
            end
        endcase
    end

    // divider is started on entry into the wait state; operands follow the caller
    always_comb
    begin
        div_req.start    = (state_next == cffcp_pkg::ST_DIV) && (state_reg != cffcp_pkg::ST_DIV);
        div_req.dividend = ((state_reg == cffcp_pkg::ST_DISPATCH) ||
                            (state_reg == cffcp_pkg::ST_OCC_DIV2)) ? DW'(cmd_reg.core) : core_reg;
        div_req.divisor  = ((state_reg == cffcp_pkg::ST_DISPATCH) ||
                            (state_reg == cffcp_pkg::ST_LOW_START)) ? cfg.cpc : cfg.cpn;
    end

    assign cl_waddr = (state_reg == cffcp_pkg::ST_CLEAR) ? clr_reg : ccl_reg[AW-1:0];
    assign nd_waddr = (state_reg == cffcp_pkg::ST_CLEAR) ? clr_reg : nidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cffcp_pkg::ST_CLEAR;
            ret_reg       <= cffcp_pkg::ST_IDLE;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            res_valid_reg <= emit;
            if (state_reg == cffcp_pkg::ST_CLEAR)
            begin
                clr_reg <= AW'(clr_reg + 1'b1);
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_head;
        end
        if (emit)
        begin
            dec_reg <= emit_dec;
            tgt_reg <= emit_tgt;
            tag_reg <= cmd_reg.tag;
        end
        unique case (state_reg)
            cffcp_pkg::ST_DIV:
            begin
                if (div_rsp.done && (ret_reg == cffcp_pkg::ST_LOW_CHK))
                begin
                    ccl_reg <= div_rsp.quotient;
                end
            end
            cffcp_pkg::ST_OCC_DIV2:
            begin
                ccl_reg <= div_rsp.quotient;
            end
            cffcp_pkg::ST_OCC_RD, cffcp_pkg::ST_LOW_NRD:
            begin
                nidx_reg <= div_rsp.quotient[AW-1:0];
            end
            cffcp_pkg::ST_NODE_CHK:
            begin
                nidx_reg <= AW'(cmd_reg.home);
            end
            cffcp_pkg::ST_LOW_MUL:
            begin
                core_reg <= DW'(cfg.cpn) * DW'(cmd_reg.home);
                i_reg    <= '0;
            end
            cffcp_pkg::ST_LOW_CMP:
            begin
                if (!cl_fit)
                begin
                    core_reg <= DW'(core_reg + DW'(cfg.cpc));
                    ccl_reg  <= DW'(ccl_reg + 1'b1);
                    i_reg    <= 10'(i_reg + 10'(cfg.cpc));
                end
            end
            default:
            begin
            end
        endcase
    end

    // load counter memories
    always_ff @(posedge clk)
    begin
        if (cl_we)
        begin
            cl_mem[cl_waddr] <= cl_wdata;
        end
        if (cl_re)
        begin
            cl_rd_reg <= cl_mem[ccl_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nd_we)
        begin
            nd_mem[nd_waddr] <= nd_wdata;
        end
        if (nd_re)
        begin
            nd_rd_reg <= nd_mem[nd_raddr];
        end
    end

    assign clearing     = (state_reg == cffcp_pkg::ST_CLEAR);
    assign result_valid = res_valid_reg;
    assign decision     = dec_reg;
    assign target       = tgt_reg;
    assign task_tag_out = tag_reg;

    `CFFCP_ASSERT(a_strobe_gap, res_valid_reg |=> !res_valid_reg, "result strobes in adjacent cycles")
    `CFFCP_ASSERT(a_div_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
    `CFFCP_ASSERT(a_no_pop_clear, (state_reg == cffcp_pkg::ST_CLEAR) |-> !q_pop, "queue popped during clear")
    `CFFCP_ASSERT(a_cluster_range, (emit && (emit_dec == cffcp_pkg::DEC_CLUSTER)) |-> (32'(core_reg) < MAX_CORES), "cluster chosen outside table")

endmodule

// ===== hw/rtl/cluster_first_fit_core_placer.sv =====
// ----------------------------------------------------------------------------
// cluster_first_fit_core_placer
// load-tracking core placer with cluster first-fit search
// ----------------------------------------------------------------------------
// A request beat is taken at a clock edge with start high and busy low. Every
// beat yields exactly one result beat, shown for one cycle with result_valid
// high; the receiver cannot stall, so results must be captured when strobed.
// After reset the block sweeps both load tables to zero, one entry a cycle,
// holding busy high (configuration writes are taken as ever). A front end
// sorts beats and queues up to two commands, so busy stays low while the
// back end works until the queue is full. Per command the back end settles
// trivial outcomes (none, unbind, package, occupy out of range) in its
// dispatch state; a die-class beat takes one node counter check, an occupy
// beat two divisions and an update of both counters, and a low-bandwidth
// place a division, a scan of the cluster counters and, when a cluster is
// taken, a further division, or else a fall-through to the node check. The
// shared bit-serial divider and the one-read-per-step scan set this cost.
// ----------------------------------------------------------------------------
module cluster_first_fit_core_placer #(
    parameter int MAX_CORES = cffcp_pkg::MAX_CORES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              start,
    output logic              busy,
    input  logic              operation,
    input  logic signed [8:0] home_node,
    input  logic [2:0]        bandwidth_class,
    input  logic [8:0]        demand,
    input  logic [21:0]       task_tag,
    input  logic [7:0]        core_index,
    // result channel
    output logic              result_valid,
    output logic [2:0]        decision,
    output logic [8:0]        target,
    output logic [21:0]       task_tag_out,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [8:0]        cfg_data
);

    // configuration registers, reset to the documented defaults
    logic [cffcp_pkg::CFG_W-1:0] cpc_reg;
    logic [cffcp_pkg::CFG_W-1:0] cpn_reg;
    logic [cffcp_pkg::CFG_W-1:0] cpp_reg;
    cffcp_pkg::cfg_t             cfg;

    // front to queue, queue to back
    logic                        push;
    cffcp_pkg::cmd_t             push_cmd;
    logic                        q_pop;
    cffcp_pkg::q_status_t        q_status;
    cffcp_pkg::cmd_t             q_head;
    logic                        clearing;

    // shared divider
    cffcp_pkg::div_req_t         div_req;
    cffcp_pkg::div_rsp_t         div_rsp;

    // writes are always taken; an index past the last register is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpc_reg <= 9'd4;
            cpn_reg <= 9'd32;
            cpp_reg <= 9'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cffcp_pkg::CFG_CPC: cpc_reg <= cfg_data;
                cffcp_pkg::CFG_CPN: cpn_reg <= cfg_data;
                cffcp_pkg::CFG_CPP: cpp_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // a register written as zero behaves as one
    always_comb
    begin
        cfg.cpc = cffcp_pkg::reg_or_one(cpc_reg);
        cfg.cpn = cffcp_pkg::reg_or_one(cpn_reg);
        cfg.cpp = cffcp_pkg::reg_or_one(cpp_reg);
    end

    // front: takes request beats and classifies them
    cffcp_front #(
        .MAX_CORES (MAX_CORES)
    ) u_front (
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .home_node       (home_node),
        .bandwidth_class (bandwidth_class),
        .demand          (demand),
        .task_tag        (task_tag),
        .core_index      (core_index),
        .q_status        (q_status),
        .clearing        (clearing),
        .push            (push),
        .cmd             (push_cmd)
    );

    // command queue decoupling front and back
    cffcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .status   (q_status),
        .head     (q_head)
    );

    // divider shared by the cluster and node index computations
    cffcp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // back: counter tables, scan sequencer and result register
    cffcp_back #(
        .MAX_CORES (MAX_CORES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_status     (q_status),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .result_valid (result_valid),
        .decision     (decision),
        .target       (target),
        .task_tag_out (task_tag_out)
    );

endmodule
